[design/gfbs_pkg.sv]
// Shared types, constants and command codes for the grouped free-block stack.
package gfbs_pkg;

	// Pool geometry.
	localparam int NUM_BLOCKS  = 256;
	localparam int GROUP_SIZE  = 16;
	localparam int STORE_DEPTH = NUM_BLOCKS * GROUP_SIZE;

	// Derived widths.
	localparam int BLOCK_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = $clog2(NUM_BLOCKS + 1);
	localparam int IDX_W     = $clog2(GROUP_SIZE);
	localparam int FILL_W    = $clog2(GROUP_SIZE + 1);
	localparam int SADDR_W   = $clog2(STORE_DEPTH);

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH   = 2;
	localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_COUNT_W = $clog2(CMD_DEPTH + 1);

	// Request operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_REJECTED  = 2'd2;

	// Request beat.
	typedef struct packed {
		logic               op;
		logic [BLOCK_W-1:0] block_in;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic [BLOCK_W-1:0]  block_out;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  free_total;
	} rsp_t;

	// Work kinds the back end carries out.
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_PUSH,
		CMD_SPILL,
		CMD_POP,
		CMD_RELOAD
	} cmd_kind_t;

	// Classified command passed from front to back.
	typedef struct packed {
		cmd_kind_t           kind;
		logic [BLOCK_W-1:0]  block;
		logic [IDX_W-1:0]    idx;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  total;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SPILL,
		BK_RELOAD,
		BK_DONE
	} back_state_t;

endpackage

[design/gfbs_front.sv]
// Front end: accepts requests, tracks stack fill and free count, and classifies each beat.
module gfbs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gfbs_pkg::req_t req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output gfbs_pkg::cmd_t cmd
);
	import gfbs_pkg::*;

	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] count_q;
	logic [FILL_W-1:0]  fill_d;
	logic [COUNT_W-1:0] count_d;
	logic [FILL_W-1:0]  fill_dec;
	logic [COUNT_W-1:0] count_dec;
	logic               accept;

	assign req_ready = cmd_ready;
	assign cmd_valid = req_valid;
	assign accept    = req_valid & cmd_ready;
	assign fill_dec  = fill_q - 1'b1;
	assign count_dec = count_q - 1'b1;

	// Classify the request against the current fill and free count.
	always_comb begin
		fill_d     = fill_q;
		count_d    = count_q;
		cmd.kind   = CMD_NOP;
		cmd.block  = req.block_in;
		cmd.idx    = fill_q[IDX_W-1:0];
		cmd.status = STAT_OK;
		cmd.total  = count_q;
		if (req.op == OP_ALLOC) begin
			if (count_q == '0 || fill_q == '0) begin
				cmd.status = STAT_EXHAUSTED;
			end else begin
				count_d   = count_dec;
				cmd.total = count_dec;
				cmd.idx   = fill_dec[IDX_W-1:0];
				if (fill_dec == '0 && count_dec != '0) begin
					// The last entry is a link to a spilled group.
					cmd.kind = CMD_RELOAD;
					fill_d   = FILL_W'(GROUP_SIZE);
				end else begin
					cmd.kind = CMD_POP;
					fill_d   = fill_dec;
				end
			end
		end else begin
			if (COUNT_W'(req.block_in) >= COUNT_W'(NUM_BLOCKS)
					|| count_q >= COUNT_W'(NUM_BLOCKS)) begin
				cmd.status = STAT_REJECTED;
			end else begin
				count_d   = count_q + 1'b1;
				cmd.total = count_q + 1'b1;
				if (fill_q >= FILL_W'(GROUP_SIZE)) begin
					cmd.kind = CMD_SPILL;
					fill_d   = FILL_W'(1);
				end else begin
					cmd.kind = CMD_PUSH;
					fill_d   = fill_q + 1'b1;
				end
			end
		end
	end

	// Bookkeeping counters are updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			fill_q  <= fill_d;
			count_q <= count_d;
		end
	end

endmodule

[design/gfbs_cmd_fifo.sv]
// Short command queue that decouples the front end from the back end.
module gfbs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  gfbs_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output gfbs_pkg::cmd_t rd_data
);
	import gfbs_pkg::*;

	cmd_t                   entries_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0]   wr_ptr_q;
	logic [CMD_PTR_W-1:0]   rd_ptr_q;
	logic [CMD_COUNT_W-1:0] level_q;
	logic                   push;
	logic                   pop;

	assign wr_ready = (level_q != CMD_COUNT_W'(CMD_DEPTH));
	assign rd_valid = (level_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[design/gfbs_back.sv]
// Back end: owns the top stack and the group store, runs spills and reloads, drives results.
module gfbs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  gfbs_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output gfbs_pkg::rsp_t rsp
);
	import gfbs_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	cmd_t               cmd_q;
	logic [BLOCK_W-1:0] given_q;
	logic [FILL_W-1:0]  cnt_q;
	logic               rd_valid_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [BLOCK_W-1:0] rdata_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [BLOCK_W-1:0] top_stack [GROUP_SIZE];
	logic [BLOCK_W-1:0] group_store [STORE_DEPTH];

	logic               take_cmd;
	logic               slot_free;
	logic               rsp_load;
	logic               spill_last;
	logic               reload_last;
	logic               issue_rd;
	logic               stk_we;
	logic [IDX_W-1:0]   stk_widx;
	logic [BLOCK_W-1:0] stk_wdata;
	logic               mem_we;
	logic [SADDR_W-1:0] mem_waddr;
	logic [SADDR_W-1:0] mem_raddr;

	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign spill_last  = (cnt_q[IDX_W-1:0] == IDX_W'(GROUP_SIZE - 1));
	assign reload_last = rd_valid_q && (rd_idx_q == IDX_W'(GROUP_SIZE - 1));
	assign issue_rd    = (state_q == BK_RELOAD) && (cnt_q < FILL_W'(GROUP_SIZE));
	assign mem_waddr   = {cmd_q.block, cnt_q[IDX_W-1:0]};
	assign mem_raddr   = {given_q, cnt_q[IDX_W-1:0]};
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_SPILL:  state_d = BK_SPILL;
						CMD_RELOAD: state_d = BK_RELOAD;
						default:    state_d = BK_DONE;
					endcase
				end
			end
			BK_SPILL: begin
				if (spill_last) begin
					state_d = BK_DONE;
				end
			end
			BK_RELOAD: begin
				if (reload_last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs: queue pop, stack and store writes, result load.
	always_comb begin
		take_cmd  = 1'b0;
		rsp_load  = 1'b0;
		stk_we    = 1'b0;
		stk_widx  = cmd.idx;
		stk_wdata = cmd.block;
		mem_we    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				take_cmd = cmd_valid;
				stk_we   = cmd_valid && (cmd.kind == CMD_PUSH);
			end
			BK_SPILL: begin
				mem_we = 1'b1;
				if (spill_last) begin
					// The freed block becomes the single link entry.
					stk_we    = 1'b1;
					stk_widx  = '0;
					stk_wdata = cmd_q.block;
				end
			end
			BK_RELOAD: begin
				stk_we    = rd_valid_q;
				stk_widx  = rd_idx_q;
				stk_wdata = rdata_q;
			end
			BK_DONE: begin
				rsp_load = slot_free;
			end
			default: begin
				take_cmd = 1'b0;
			end
		endcase
	end

	assign cmd_ready = take_cmd;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			rd_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= issue_rd;
			if (take_cmd) begin
				cnt_q <= '0;
			end else if (state_q == BK_SPILL || issue_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command capture, popped block and result payload.
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			cmd_q <= cmd;
			unique case (cmd.kind)
				CMD_POP:    given_q <= top_stack[cmd.idx];
				CMD_RELOAD: given_q <= top_stack[0];
				default:    given_q <= '0;
			endcase
		end
		rd_idx_q <= cnt_q[IDX_W-1:0];
		if (rsp_load) begin
			rsp_q.block_out  <= given_q;
			rsp_q.status     <= cmd_q.status;
			rsp_q.free_total <= cmd_q.total;
		end
	end

	// Top stack storage.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			top_stack[stk_widx] <= stk_wdata;
		end
	end

	// Group store memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			group_store[mem_waddr] <= top_stack[cnt_q[IDX_W-1:0]];
		end
		rdata_q <= group_store[mem_raddr];
	end

endmodule

[design/grouped_free_block_stack.sv]
// Top level of the grouped free-block stack allocator.
//
// Requests arrive on req_valid/req_ready with a req beat: op selects allocate
// or free, block_in names the block to free. Every request produces exactly
// one result beat on rsp_valid/rsp_ready carrying the allocated block, a
// status code and the free count after the request.
//
// A front end classifies each request against its own fill and free counts
// and places a command in a two-entry queue. The back end owns the top stack
// and the 4096-entry group store and carries the command out.
// A plain allocate, plain free or refused request is written into the queue,
// taken by the back end into its done state and then loaded into the output
// register. A free onto a full stack writes sixteen entries into the group
// store, one per cycle. An allocate that pops a link reads sixteen entries
// back through the store's registered read port. The back end takes a new
// command only when idle, after the result of the last one is loaded, so
// copying sixteen entries one at a time holds it in a spill or reload.
// Reset empties the pool: the free count and fill are zero, and no clearing
// pass runs. When the receiver stalls, one result waits in the output
// register while the queue keeps taking requests until it fills.
module grouped_free_block_stack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  gfbs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output gfbs_pkg::rsp_t rsp
);
	import gfbs_pkg::*;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	// Classification of incoming requests.
	gfbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// Command queue between the two halves.
	gfbs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_cmd)
	);

	// Stack and group store execution.
	gfbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
